// ----- rtl/gcl_pkg.sv -----
// gcl_pkg: widths and constants shared by the gcd/lcm unit.
// No dependencies; imported by gcl_divider, gcd_lcm_unit and the bench.
package gcl_pkg;

  // operand width as two's complement, taken from the low bits of each field
  localparam int OPERAND_WIDTH = 32;
  // magnitude width of a positive operand
  localparam int MAG_W  = OPERAND_WIDTH - 1;
  // counter wide enough to hold MAG_W itself
  localparam int CNT_W  = $clog2(MAG_W + 1);
  localparam int PROD_W = 2 * MAG_W;

  // result field widths
  localparam int GCD_W = 31;
  localparam int LCM_W = 62;

  // stream payload layout
  localparam int FIELD_W    = 32;
  localparam int A_LSB      = 0;
  localparam int B_LSB      = FIELD_W;
  localparam int IN_DATA_W  = 2 * FIELD_W;
  localparam int OUT_DATA_W = ((GCD_W + LCM_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - GCD_W - LCM_W;

endpackage

// ----- rtl/gcl_divider.sv -----
// gcl_divider: restoring radix-2 divider, one quotient bit per cycle.
// Depends on gcl_pkg. Used by gcd_lcm_unit for the multiple's quotient.
module gcl_divider (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [gcl_pkg::MAG_W-1:0] dividend,
  input  logic [gcl_pkg::MAG_W-1:0] divisor,
  output logic                  done,
  output logic [gcl_pkg::MAG_W-1:0] quotient
);
  import gcl_pkg::*;

  logic [MAG_W-1:0] rem, rem_next;
  logic [MAG_W-1:0] quo, quo_next;
  logic [MAG_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic [MAG_W:0]   rem_sh;
  logic [MAG_W:0]   trial;
  logic             take;

  // one shift-subtract step
  always_comb begin
    rem_sh   = {rem, quo[MAG_W-1]};
    trial    = rem_sh - {1'b0, dvs};
    take     = ~trial[MAG_W];
    rem_next = take ? trial[MAG_W-1:0] : rem_sh[MAG_W-1:0];
    quo_next = {quo[MAG_W-2:0], take};
  end

  // iteration control; quotient bits shift in where the dividend shifts out
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem     <= '0;
        quo     <= dividend;
        dvs     <= divisor;
        cnt     <= CNT_W'(MAG_W);
        running <= 1'b1;
      end else if (running) begin
        rem <= rem_next;
        quo <= quo_next;
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// ----- rtl/gcd_lcm_unit.sv -----
// gcd_lcm_unit: greatest common divisor and least common multiple of two
// signed operands. Depends on gcl_pkg and gcl_divider.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata: value_a, value_b
//  m_*       out  m_tvalid/m_tready  m_tdata: gcd_out, lcm_out
//
// An item with two positive operands is taken in the idle state, then runs the
// binary GCD loop on the shared subtract/shift unit, one step per cycle (at
// most 2*(OPERAND_WIDTH-1)-1 steps), until u or v is zero. S_FIN then latches
// the gcd and starts the divider on operand a over the gcd; when it is done,
// its quotient times operand b is latched as the lcm, and S_OUT loads the
// output once it is free. A non-positive operand gives zero results directly.
// s_tready is high only while the sequencer idles; the output register
// holds a result under stall while the next item is taken.
// rst is synchronous and clears the sequencer and the output valid.
module gcd_lcm_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [31:0] value_a, [63:32] value_b
  input  logic [gcl_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [30:0] gcd_out, [92:31] lcm_out, [95:93] zero
  output logic [gcl_pkg::OUT_DATA_W-1:0] m_tdata
);
  import gcl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD,
    S_FIN,
    S_DIV,
    S_OUT
  } state_t;

  state_t state;

  logic [OPERAND_WIDTH-1:0] op_a, op_b;
  logic                     pos_a, pos_b;
  logic [MAG_W-1:0]         a_mag, b_mag;
  logic [MAG_W-1:0]         u, v, u_next, v_next;
  logic [CNT_W-1:0]         k, k_next;
  logic [MAG_W:0]           diff;
  logic [MAG_W-1:0]         gshift;
  logic [MAG_W-1:0]         g_res;
  logic [LCM_W-1:0]         lcm_res;
  logic [PROD_W-1:0]        product;
  logic [GCD_W-1:0]         gcd_q;
  logic [LCM_W-1:0]         lcm_q;
  logic                     div_start, div_done;
  logic [MAG_W-1:0]         div_quo;
  logic                     accept;
  logic                     out_free;

  // operand decode
  always_comb begin
    op_a  = s_tdata[A_LSB +: OPERAND_WIDTH];
    op_b  = s_tdata[B_LSB +: OPERAND_WIDTH];
    pos_a = ~op_a[OPERAND_WIDTH-1] && (op_a != '0);
    pos_b = ~op_b[OPERAND_WIDTH-1] && (op_b != '0);
  end

  // binary GCD step: one compare/subtract and one shift
  always_comb begin
    diff   = {1'b0, u} - {1'b0, v};
    u_next = u;
    v_next = v;
    k_next = k;
    if (!u[0] && !v[0]) begin
      u_next = u >> 1;
      v_next = v >> 1;
      k_next = k + 1'b1;
    end else if (!u[0]) begin
      u_next = u >> 1;
    end else if (!v[0]) begin
      v_next = v >> 1;
    end else if (!diff[MAG_W]) begin
      u_next = diff[MAG_W:1];
    end else begin
      v_next = MAG_W'((~diff + 1'b1) >> 1);
    end
  end

  // restore common factors of two
  assign gshift    = (u | v) << k;
  assign div_start = (state == S_FIN);
  assign product   = PROD_W'(div_quo) * PROD_W'(b_mag);

  gcl_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (a_mag),
    .divisor  (gshift),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // result leaves unless a new one is loaded in the same cycle
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (pos_a && pos_b) begin
              a_mag <= op_a[MAG_W-1:0];
              b_mag <= op_b[MAG_W-1:0];
              u     <= op_a[MAG_W-1:0];
              v     <= op_b[MAG_W-1:0];
              k     <= '0;
              state <= S_GCD;
            end else begin
              g_res   <= '0;
              lcm_res <= '0;
              state   <= S_OUT;
            end
          end
        end
        S_GCD: begin
          if (u == '0 || v == '0) begin
            state <= S_FIN;
          end else begin
            u <= u_next;
            v <= v_next;
            k <= k_next;
          end
        end
        S_FIN: begin
          g_res <= gshift;
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            lcm_res <= LCM_W'(product);
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            gcd_q    <= GCD_W'(g_res);
            lcm_q    <= lcm_res;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, lcm_q, gcd_q};

endmodule

// ----- bench/gcd_lcm_checker.sv -----
// gcd_lcm_checker: watches both stream channels of gcd_lcm_unit, predicts the gcd and lcm
// of every accepted item and compares each result field by field, in order.
// Depends on gcl_pkg for operand width and payload layout.
`timescale 1ns / 100ps

module gcd_lcm_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  // [31:0] value_a, [63:32] value_b
  input  logic [gcl_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  // [30:0] gcd_out, [92:31] lcm_out, [95:93] zero
  input  logic [gcl_pkg::OUT_DATA_W-1:0] m_tdata,
  output int                             outstanding,
  output int                             fail_count
);
  import gcl_pkg::*;

  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    logic [LCM_W-1:0]     lcm;
    logic [GCD_W-1:0]     gcd;
  } gcd_lcm_t;

  gcd_lcm_t pending_results[$];
  int       error_total = 0;

  // Operand is usable only if its low OPERAND_WIDTH bits form a positive number
  function automatic bit operand_positive(input logic [FIELD_W-1:0] raw,
                                          output longint unsigned mag);
    longint unsigned field;
    field = 64'(raw) & ((64'd1 << OPERAND_WIDTH) - 64'd1);
    mag   = field;
    return field != 0 && field[OPERAND_WIDTH-1] == 1'b0;
  endfunction

  function automatic gcd_lcm_t divisor_and_multiple(input logic [FIELD_W-1:0] raw_a,
                                                    input logic [FIELD_W-1:0] raw_b);
    longint unsigned big, tiny, rem, g, lo_op;
    gcd_lcm_t        res;
    bit              ok_a, ok_b;
    res  = '0;
    ok_a = operand_positive(raw_a, big);
    ok_b = operand_positive(raw_b, tiny);
    if (ok_a && ok_b) begin
      // larger operand first, then Euclid
      if (tiny > big) begin
        rem  = big;
        big  = tiny;
        tiny = rem;
      end
      lo_op = tiny;
      g = big;
      rem = tiny;
      while (rem != 0) begin
        tiny = g % rem;
        g    = rem;
        rem  = tiny;
      end
      // product over divisor, divided first so nothing exceeds the result width
      res.gcd = GCD_W'(g);
      res.lcm = LCM_W'((big / g) * lo_op);
    end
    return res;
  endfunction

  task automatic log_error(input string what, input gcd_lcm_t want, input gcd_lcm_t got);
    error_total++;
    if (error_total <= 10)
      $display("[%0t] gcd/lcm error (%s): expected gcd=%0d lcm=%0d pad=%0d,",
               $time, what, want.gcd, want.lcm, want.pad,
               " got gcd=%0d lcm=%0d pad=%0d", got.gcd, got.lcm, got.pad);
  endtask

  // Input items queue a prediction, results retire the oldest one
  always @(posedge clk) begin
    gcd_lcm_t got;
    gcd_lcm_t want;
    if (rst) begin
      pending_results.delete();
      outstanding <= 0;
    end else begin
      if (s_tvalid && s_tready)
        pending_results.push_back(divisor_and_multiple(s_tdata[A_LSB +: FIELD_W],
                                                       s_tdata[B_LSB +: FIELD_W]));
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (pending_results.size() == 0) begin
          log_error("result with nothing pending", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got.gcd !== want.gcd) log_error("gcd_out", want, got);
          if (got.lcm !== want.lcm) log_error("lcm_out", want, got);
          if (got.pad !== want.pad) log_error("padding", want, got);
        end
      end
      outstanding <= pending_results.size();
    end
    fail_count <= error_total;
  end

endmodule

// ----- bench/testbench.sv -----
// testbench: drives directed and random operand pairs into gcd_lcm_unit with random idling
// on both sides; gcd_lcm_checker does the prediction. Depends on gcl_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
  import gcl_pkg::*;

  localparam int RANDOM_ITEMS = 1550;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 200;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  int                    outstanding;
  int                    fail_count;
  int                    cycle_count = 0;
  bit                    no_idle = 1'b0;

  gcd_lcm_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  gcd_lcm_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  always #6 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one item after a random gap; valid stays high into the next item when no gap
  task automatic send_pair(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, a};
    do @(posedge clk); while (!(s_tvalid && s_tready));
  endtask

  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Operand: mostly positive with a random bit length, sometimes zero or negative
  function automatic logic [FIELD_W-1:0] random_operand();
    int pick;
    logic [FIELD_W-1:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 4) return '0;
    if (pick < 10) return $urandom() | 32'h8000_0000;
    v = $urandom() >> $urandom_range(1, 31);
    return (v == 0) ? 32'd1 : v;
  endfunction

  // Receiver: random stall per result, with idle-free stretches
  initial begin : result_sink
    int stall;
    @(negedge rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  initial begin : stimulus
    logic [FIELD_W-1:0] a, b, g;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Non-positive operands: zero, minus one, most negative
    send_pair(32'd0, 32'd0);
    send_pair(32'd0, 32'd5);
    send_pair(32'd5, 32'd0);
    send_pair(32'hFFFF_FFFF, 32'd7);
    send_pair(32'd7, 32'hFFFF_FFFF);
    send_pair(32'h8000_0000, 32'h8000_0000);
    send_pair(32'h8000_0000, 32'd1);
    send_pair(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    // Largest operands and the widest multiple
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFE);
    send_pair(32'd1, 32'h7FFF_FFFF);
    send_pair(32'h7FFF_FFFF, 32'd1);
    send_pair(32'd1, 32'd1);
    // Operand order must not matter
    send_pair(32'd12, 32'd18);
    send_pair(32'd18, 32'd12);
    send_pair(32'd6, 32'd6);
    // Consecutive Fibonacci numbers: longest Euclid chain
    send_pair(32'd1836311903, 32'd1134903170);
    send_pair(32'd1134903170, 32'd1836311903);
    send_pair(32'h4000_0000, 32'h2000_0000);
    send_pair(32'h5555_5555, 32'h2AAA_AAAA);
    send_pair(32'd2147483629, 32'd2147483587);
    wait_all_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      no_idle = (i >= 200 && i < 400) || (i >= 1100 && i < 1200);
      if (i == 700) wait_all_results();
      if ($urandom_range(0, 99) < 40) begin
        // shared factor so the divisor is usually non-trivial
        g = $urandom_range(1, 1 << $urandom_range(1, 16));
        a = g * $urandom_range(1, 32'h7FFF_FFFF / g);
        b = g * $urandom_range(1, 32'h7FFF_FFFF / g);
      end else begin
        a = random_operand();
        b = random_operand();
      end
      send_pair(a, b);
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
